// ===== rtl/wtsac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsac_pkg
// Shared types, address geometry and codes for the write-through cache.
// ----------------------------------------------------------------------------
package wtsac_pkg;

  localparam int ADDR_W     = 32;
  localparam int DATA_W     = 32;
  localparam int SET_COUNT  = 16;
  localparam int LINE_WORDS = 8;
  localparam int WAYS_DEF   = 2;

  localparam int SET_W  = $clog2(SET_COUNT);
  localparam int WORD_W = $clog2(LINE_WORDS);

  // byte address layout: tag | set | word | byte
  localparam int WORD_LSB = 2;
  localparam int SET_LSB  = WORD_LSB + WORD_W;
  localparam int TAG_LSB  = SET_LSB + SET_W;
  localparam int TAG_W    = ADDR_W - TAG_LSB;

  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(LINE_WORDS - 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STORE = 2'd1,
    OP_FILL  = 2'd2,
    OP_RSVD  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_HIT       = 3'd0,
    ST_MISS      = 3'd1,
    ST_FILL      = 3'd2,
    ST_FILL_DONE = 3'd3,
    ST_STORE     = 3'd4,
    ST_BUSY      = 3'd5,
    ST_STRAY     = 3'd6
  } status_t;

  // write-back commands from the control to the way storage
  typedef struct packed {
    logic              tag_we;     // new tag into way 0
    logic              valid_clr0; // way 0 of set goes invalid
    logic              valid_set0; // way 0 of set becomes valid
    logic              data_we;
    logic              data_fill;  // 1: way 0, 0: the hitting way
    logic [SET_W-1:0]  set;
    logic [WORD_W-1:0] word;
    logic [TAG_W-1:0]  tag;
    logic [DATA_W-1:0] data;
  } wr_t;

  function automatic logic [SET_W-1:0] addr_set(input logic [ADDR_W-1:0] a);
    return a[TAG_LSB-1:SET_LSB];
  endfunction

  function automatic logic [WORD_W-1:0] addr_word(input logic [ADDR_W-1:0] a);
    return a[SET_LSB-1:WORD_LSB];
  endfunction

  function automatic logic [TAG_W-1:0] addr_tag(input logic [ADDR_W-1:0] a);
    return a[ADDR_W-1:TAG_LSB];
  endfunction

endpackage

// ===== rtl/wtsac_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsac_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wtsac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/wtsac_ways.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtsac_ways
// Tag and data RAMs per way, valid bits, parallel tag compare and write-back.
// ----------------------------------------------------------------------------
module wtsac_ways #(
  parameter int WAYS = wtsac_pkg::WAYS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // read launch, in the cycle before the lookup
  input  logic                           rd_en,
  input  logic [wtsac_pkg::SET_W-1:0]    rd_set,
  input  logic [wtsac_pkg::WORD_W-1:0]   rd_word,
  // lookup cycle
  input  logic [wtsac_pkg::SET_W-1:0]    cmp_set,
  input  logic [wtsac_pkg::TAG_W-1:0]    cmp_tag,
  input  wtsac_pkg::wr_t                 wr,
  output logic                           hit,
  output logic [wtsac_pkg::DATA_W-1:0]   hit_data,
  output logic [wtsac_pkg::DATA_W-1:0]   way0_data
);

  localparam int DADDR_W = wtsac_pkg::SET_W + wtsac_pkg::WORD_W;

  logic [wtsac_pkg::SET_COUNT-1:0][WAYS-1:0] valid_r;
  logic [wtsac_pkg::TAG_W-1:0]  tag_q  [WAYS];
  logic [wtsac_pkg::DATA_W-1:0] data_q [WAYS];
  logic [WAYS-1:0] match;
  logic [WAYS-1:0] first;

  for (genvar j = 0; j < WAYS; j++) begin : g_way
    wtsac_ram #(
      .WIDTH (wtsac_pkg::TAG_W),
      .DEPTH (wtsac_pkg::SET_COUNT)
    ) u_tag (
      .clk   (clk),
      .we    (wr.tag_we && (j == 0)),
      .waddr (wr.set),
      .wdata (wr.tag),
      .re    (rd_en),
      .raddr (rd_set),
      .rdata (tag_q[j])
    );

    wtsac_ram #(
      .WIDTH (wtsac_pkg::DATA_W),
      .DEPTH (wtsac_pkg::SET_COUNT * wtsac_pkg::LINE_WORDS)
    ) u_data (
      .clk   (clk),
      .we    (wr.data_we && (wr.data_fill ? (j == 0) : first[j])),
      .waddr (DADDR_W'({wr.set, wr.word})),
      .wdata (wr.data),
      .re    (rd_en),
      .raddr (DADDR_W'({rd_set, rd_word})),
      .rdata (data_q[j])
    );

    assign match[j] = valid_r[cmp_set][j] && (tag_q[j] == cmp_tag);
  end

  // lowest matching way wins
  always_comb begin
    logic found;
    found    = 1'b0;
    first    = '0;
    hit_data = '0;
    for (int j = 0; j < WAYS; j++) begin
      if (match[j] && !found) begin
        first[j] = 1'b1;
        hit_data = data_q[j];
      end
      found = found | match[j];
    end
  end

  assign hit       = |match;
  assign way0_data = data_q[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.valid_clr0) begin
      valid_r[wr.set][0] <= 1'b0;
    end else if (wr.valid_set0) begin
      valid_r[wr.set][0] <= 1'b1;
    end
  end

endmodule

// ===== rtl/write_through_set_assoc_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// write_through_set_assoc_cache
// Write-through, no-write-allocate set-associative cache with line fill.
// ----------------------------------------------------------------------------
// Timing: a taken request is registered into the lookup state together with
//   the tag/data RAM read; out_valid and the result are registered from it.
// Requests: a new request is taken only while busy is low; busy covers the
//   lookup state, which the registered RAM read puts before compare/write-back.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset: synchronous; counters, fill state and all valid bits clear at once.
module write_through_set_assoc_cache #(
  parameter int WAYS_PER_SET = wtsac_pkg::WAYS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_opcode,
  input  logic [wtsac_pkg::ADDR_W-1:0] in_address,
  input  logic [wtsac_pkg::DATA_W-1:0] in_data_in,
  output logic                         out_valid,
  output logic [2:0]                   out_status,
  output logic                         out_hit,
  output logic [wtsac_pkg::DATA_W-1:0] out_read_data,
  output logic                         out_mem_write,
  output logic                         out_mem_read,
  output logic [wtsac_pkg::ADDR_W-1:0] out_mem_address,
  output logic [wtsac_pkg::DATA_W-1:0] out_mem_data,
  output logic [31:0]                  out_hit_count,
  output logic [31:0]                  out_miss_count
);

  typedef enum logic {S_IDLE, S_LOOK} state_t;

  state_t                         state_r;
  wtsac_pkg::opcode_t             op_r;
  logic [wtsac_pkg::ADDR_W-1:0]   addr_r;
  logic [wtsac_pkg::DATA_W-1:0]   din_r;
  logic                           fill_pending_r, fill_pending_nxt;
  logic [wtsac_pkg::WORD_W-1:0]   fill_cnt_r, fill_cnt_nxt;
  logic [wtsac_pkg::SET_W-1:0]    pend_set_r, pend_set_nxt;
  logic [wtsac_pkg::WORD_W-1:0]   pend_word_r, pend_word_nxt;
  logic [31:0]                    hits_r, hits_nxt;
  logic [31:0]                    misses_r, misses_nxt;

  logic                           out_valid_r;
  wtsac_pkg::status_t             out_status_r, status_nxt;
  logic                           out_hit_r, hit_nxt;
  logic [wtsac_pkg::DATA_W-1:0]   out_rdata_r, rdata_nxt;
  logic                           out_mwr_r, mwr_nxt;
  logic                           out_mrd_r, mrd_nxt;
  logic [wtsac_pkg::ADDR_W-1:0]   out_maddr_r, maddr_nxt;
  logic [wtsac_pkg::DATA_W-1:0]   out_mdata_r, mdata_nxt;

  logic                           accept;
  logic [wtsac_pkg::SET_W-1:0]    rd_set;
  logic [wtsac_pkg::WORD_W-1:0]   rd_word;
  wtsac_pkg::wr_t                 wr;
  logic                           lk_hit;
  logic [wtsac_pkg::DATA_W-1:0]   lk_hit_data;
  logic [wtsac_pkg::DATA_W-1:0]   lk_way0_data;

  assign busy   = (state_r == S_LOOK);
  assign accept = start && !busy;

  // fill requests read the word the pending load asked for
  always_comb begin
    if (wtsac_pkg::opcode_t'(in_opcode) == wtsac_pkg::OP_FILL) begin
      rd_set  = pend_set_r;
      rd_word = pend_word_r;
    end else begin
      rd_set  = wtsac_pkg::addr_set(in_address);
      rd_word = wtsac_pkg::addr_word(in_address);
    end
  end

  wtsac_ways #(
    .WAYS (WAYS_PER_SET)
  ) u_ways (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_set    (rd_set),
    .rd_word   (rd_word),
    .cmp_set   (wtsac_pkg::addr_set(addr_r)),
    .cmp_tag   (wtsac_pkg::addr_tag(addr_r)),
    .wr        (wr),
    .hit       (lk_hit),
    .hit_data  (lk_hit_data),
    .way0_data (lk_way0_data)
  );

  always_comb begin
    fill_pending_nxt = fill_pending_r;
    fill_cnt_nxt     = fill_cnt_r;
    pend_set_nxt     = pend_set_r;
    pend_word_nxt    = pend_word_r;
    hits_nxt         = hits_r;
    misses_nxt       = misses_r;
    status_nxt       = wtsac_pkg::ST_BUSY;
    hit_nxt          = 1'b0;
    rdata_nxt        = '0;
    mwr_nxt          = 1'b0;
    mrd_nxt          = 1'b0;
    maddr_nxt        = '0;
    mdata_nxt        = '0;
    wr               = '0;
    wr.set           = wtsac_pkg::addr_set(addr_r);
    wr.word          = wtsac_pkg::addr_word(addr_r);
    wr.tag           = wtsac_pkg::addr_tag(addr_r);
    wr.data          = din_r;

    if (state_r == S_LOOK) begin
      case (op_r)
        wtsac_pkg::OP_FILL: begin
          if (!fill_pending_r) begin
            status_nxt = wtsac_pkg::ST_STRAY;
          end else begin
            wr.data_we   = 1'b1;
            wr.data_fill = 1'b1;
            wr.set       = pend_set_r;
            wr.word      = fill_cnt_r;
            if (fill_cnt_r == wtsac_pkg::LAST_WORD) begin
              wr.valid_set0    = 1'b1;
              fill_pending_nxt = 1'b0;
              fill_cnt_nxt     = '0;
              // the asked-for word may be the one arriving now
              rdata_nxt  = (pend_word_r == fill_cnt_r) ? din_r : lk_way0_data;
              status_nxt = wtsac_pkg::ST_FILL_DONE;
            end else begin
              fill_cnt_nxt = fill_cnt_r + 1'b1;
              status_nxt   = wtsac_pkg::ST_FILL;
            end
          end
        end
        wtsac_pkg::OP_LOAD: begin
          if (!fill_pending_r) begin
            if (lk_hit) begin
              rdata_nxt  = lk_hit_data;
              hits_nxt   = hits_r + 32'd1;
              hit_nxt    = 1'b1;
              status_nxt = wtsac_pkg::ST_HIT;
            end else begin
              misses_nxt       = misses_r + 32'd1;
              wr.valid_clr0    = 1'b1;
              wr.tag_we        = 1'b1;
              fill_pending_nxt = 1'b1;
              fill_cnt_nxt     = '0;
              pend_set_nxt     = wtsac_pkg::addr_set(addr_r);
              pend_word_nxt    = wtsac_pkg::addr_word(addr_r);
              mrd_nxt          = 1'b1;
              maddr_nxt = {addr_r[wtsac_pkg::ADDR_W-1:wtsac_pkg::SET_LSB],
                           {wtsac_pkg::SET_LSB{1'b0}}};
              status_nxt       = wtsac_pkg::ST_MISS;
            end
          end
        end
        wtsac_pkg::OP_STORE: begin
          if (!fill_pending_r) begin
            // no write-allocate: the cached word changes only on a hit
            wr.data_we = lk_hit;
            hit_nxt    = lk_hit;
            mwr_nxt    = 1'b1;
            maddr_nxt  = addr_r;
            mdata_nxt  = din_r;
            status_nxt = wtsac_pkg::ST_STORE;
          end
        end
        default: begin
          status_nxt = wtsac_pkg::ST_BUSY;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      fill_pending_r <= 1'b0;
      fill_cnt_r     <= '0;
      pend_set_r     <= '0;
      pend_word_r    <= '0;
      hits_r         <= '0;
      misses_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_r        <= S_IDLE;
          out_valid_r    <= 1'b1;
          fill_pending_r <= fill_pending_nxt;
          fill_cnt_r     <= fill_cnt_nxt;
          pend_set_r     <= pend_set_nxt;
          pend_word_r    <= pend_word_nxt;
          hits_r         <= hits_nxt;
          misses_r       <= misses_nxt;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= wtsac_pkg::opcode_t'(in_opcode);
      addr_r <= in_address;
      din_r  <= in_data_in;
    end
    if (state_r == S_LOOK) begin
      out_status_r <= status_nxt;
      out_hit_r    <= hit_nxt;
      out_rdata_r  <= rdata_nxt;
      out_mwr_r    <= mwr_nxt;
      out_mrd_r    <= mrd_nxt;
      out_maddr_r  <= maddr_nxt;
      out_mdata_r  <= mdata_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_hit         = out_hit_r;
  assign out_read_data   = out_rdata_r;
  assign out_mem_write   = out_mwr_r;
  assign out_mem_read    = out_mrd_r;
  assign out_mem_address = out_maddr_r;
  assign out_mem_data    = out_mdata_r;
  assign out_hit_count   = hits_r;
  assign out_miss_count  = misses_r;

`ifndef SYNTHESIS
  a_look_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy && out_valid)
    else $error("lookup did not finish in one cycle");

  a_strobe_follows_look: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !out_valid)
    else $error("result strobe without a lookup");

  a_miss_opens_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == wtsac_pkg::ST_MISS) |-> fill_pending_r)
    else $error("miss reported without a pending fill");

  a_count_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_cnt_r != '0) |-> fill_pending_r)
    else $error("fill counter running with no fill pending");
`endif

endmodule
